### hdl/bca_pkg.sv
// Shared types, constants and helpers for the bucketize conditional accumulator.
package bca_pkg;

    localparam int DEF_MAX_BINS      = 16;
    localparam int DEF_MAX_FEATURES  = 2;
    localparam int DEF_COMBINED_BINS = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 8;
    localparam int VAL_W      = 32;
    localparam int WGT_W      = 16;
    localparam int DENS_W     = 48;
    localparam int SUM_W      = 64;
    localparam int ERR_W      = 63;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ACCUM   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_DENS = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RD_BIN  = 2'd3;

    localparam logic [1:0] KIND_NUM = 2'd0;

    localparam logic [SLOT_W-1:0] CLEAR_SLOT = 8'd255;

    localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_MAX  = {ERR_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FEATURE_COUNT = 3'd0,
        REG_KIND_FIRST    = 3'd1,
        REG_KIND_SECOND   = 3'd2,
        REG_BINS_FIRST    = 3'd3,
        REG_BINS_SECOND   = 3'd4,
        REG_CONST_FIRST   = 3'd5,
        REG_CONST_SECOND  = 3'd6,
        REG_TASK_MODE     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0] feature_count;
        logic [1:0] kind_first;
        logic [1:0] kind_second;
        logic [4:0] bins_first;
        logic [4:0] bins_second;
        logic       constant_first;
        logic       constant_second;
        logic       task_mode;
    } t_cfg;

    function automatic logic signed [SUM_W-1:0] sat_add64(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

### hdl/bca_cfg.sv
// Configuration register file.
module bca_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bca_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bca_pkg::t_cfg                     o_cfg
);

    bca_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_count   <= 2'd1;
            r_cfg.kind_first      <= 2'd0;
            r_cfg.kind_second     <= 2'd0;
            r_cfg.bins_first      <= 5'd2;
            r_cfg.bins_second     <= 5'd2;
            r_cfg.constant_first  <= 1'b0;
            r_cfg.constant_second <= 1'b0;
            r_cfg.task_mode       <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (bca_pkg::t_reg_idx'(i_cfg_index))
                bca_pkg::REG_FEATURE_COUNT: r_cfg.feature_count   <= i_cfg_data[1:0];
                bca_pkg::REG_KIND_FIRST:    r_cfg.kind_first      <= i_cfg_data[1:0];
                bca_pkg::REG_KIND_SECOND:   r_cfg.kind_second     <= i_cfg_data[1:0];
                bca_pkg::REG_BINS_FIRST:    r_cfg.bins_first      <= i_cfg_data;
                bca_pkg::REG_BINS_SECOND:   r_cfg.bins_second     <= i_cfg_data;
                bca_pkg::REG_CONST_FIRST:   r_cfg.constant_first  <= i_cfg_data[0];
                bca_pkg::REG_CONST_SECOND:  r_cfg.constant_second <= i_cfg_data[0];
                bca_pkg::REG_TASK_MODE:     r_cfg.task_mode       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

### hdl/bca_mul.sv
// Shared signed multiplier with a registered product.
module bca_mul (
    input  logic                                i_clk,
    input  logic signed [bca_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [bca_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [bca_pkg::MUL_P_W-1:0]  o_p
);

    logic signed [bca_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### hdl/bca_store.sv
// Combined-bin sum memories: prediction, truth and squared error.
module bca_store #(
    parameter int DEPTH = bca_pkg::DEF_COMBINED_BINS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_addr,
    input  logic signed [bca_pkg::SUM_W-1:0]   i_pred_wr,
    input  logic signed [bca_pkg::SUM_W-1:0]   i_truth_wr,
    input  logic [bca_pkg::ERR_W-1:0]          i_err_wr,
    output logic signed [bca_pkg::SUM_W-1:0]   o_pred_rd,
    output logic signed [bca_pkg::SUM_W-1:0]   o_truth_rd,
    output logic [bca_pkg::ERR_W-1:0]          o_err_rd
);

    logic signed [bca_pkg::SUM_W-1:0] r_pred_mem  [DEPTH];
    logic signed [bca_pkg::SUM_W-1:0] r_truth_mem [DEPTH];
    logic [bca_pkg::ERR_W-1:0]        r_err_mem   [DEPTH];
    logic signed [bca_pkg::SUM_W-1:0] r_pred_rd;
    logic signed [bca_pkg::SUM_W-1:0] r_truth_rd;
    logic [bca_pkg::ERR_W-1:0]        r_err_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pred_mem[i_addr]  <= i_pred_wr;
            r_truth_mem[i_addr] <= i_truth_wr;
            r_err_mem[i_addr]   <= i_err_wr;
        end
        r_pred_rd  <= r_pred_mem[i_addr];
        r_truth_rd <= r_truth_mem[i_addr];
        r_err_rd   <= r_err_mem[i_addr];
    end

    assign o_pred_rd  = r_pred_rd;
    assign o_truth_rd = r_truth_rd;
    assign o_err_rd   = r_err_rd;

endmodule

### hdl/bca_core.sv
// Sequencer: bin search, shared multiplier schedule and bin store updates.
module bca_core #(
    parameter int MAX_BINS      = bca_pkg::DEF_MAX_BINS,
    parameter int MAX_FEATURES  = bca_pkg::DEF_MAX_FEATURES,
    parameter int COMBINED_BINS = bca_pkg::DEF_COMBINED_BINS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bca_pkg::t_cfg                        i_cfg,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bca_pkg::FUNC_W-1:0]           i_func,
    input  logic                                 i_feature_sel,
    input  logic [bca_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_value_first,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_value_second,
    input  logic [bca_pkg::WGT_W-1:0]            i_weight,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_prediction,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_ground_truth,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [bca_pkg::SLOT_W-1:0]           o_bin_index,
    output logic [bca_pkg::DENS_W-1:0]           o_density_count,
    output logic signed [bca_pkg::SUM_W-1:0]     o_prediction_sum,
    output logic signed [bca_pkg::SUM_W-1:0]     o_truth_sum,
    output logic [bca_pkg::ERR_W-1:0]            o_squared_error_sum,
    output logic [bca_pkg::DENS_W-1:0]           o_observation_total,
    output logic                                 o_range_error
);

    localparam int BW      = $clog2(MAX_BINS);
    localparam int NBW     = $clog2(MAX_BINS + 1);
    localparam int NBOUNDS = MAX_BINS - 1;
    localparam int CW      = $clog2(COMBINED_BINS);
    localparam int CMBW    = $clog2(MAX_BINS * MAX_BINS);
    localparam int ACC_W   = 81;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SRCH, ST_COMB, ST_CHK, ST_P, ST_T, ST_X,
        ST_E0, ST_E1, ST_E2, ST_UPD, ST_WR, ST_RD, ST_RDW, ST_DONE
    } t_state;

    t_state r_state;
    logic   r_clr_cmd;
    logic   r_feat;
    logic [BW-1:0] r_idx;
    logic [BW-1:0] r_b0;
    logic [BW-1:0] r_b1;
    logic [CMBW-1:0] r_comb;
    logic [CW-1:0] r_addr;

    logic [bca_pkg::FUNC_W-1:0]       r_func;
    logic                             r_sel;
    logic [bca_pkg::SLOT_W-1:0]       r_slot;
    logic signed [bca_pkg::VAL_W-1:0] r_v0;
    logic signed [bca_pkg::VAL_W-1:0] r_v1;
    logic [bca_pkg::WGT_W-1:0]        r_w;
    logic signed [bca_pkg::VAL_W-1:0] r_pred;
    logic signed [bca_pkg::VAL_W-1:0] r_truth;

    logic signed [bca_pkg::VAL_W-1:0] r_bnd0 [NBOUNDS];
    logic signed [bca_pkg::VAL_W-1:0] r_bnd1 [NBOUNDS];
    logic [bca_pkg::DENS_W-1:0]       r_dens0 [MAX_BINS];
    logic [bca_pkg::DENS_W-1:0]       r_dens1 [MAX_BINS];
    logic [bca_pkg::DENS_W-1:0]       r_total;

    logic signed [47:0]               r_pp;
    logic signed [47:0]               r_tp;
    logic [32:0]                      r_m;
    logic [47:0]                      r_x;
    logic [ACC_W-1:0]                 r_acc;
    logic [bca_pkg::ERR_W-1:0]        r_wsq;
    logic signed [bca_pkg::SUM_W-1:0] r_ps_new;
    logic signed [bca_pkg::SUM_W-1:0] r_ts_new;

    logic [bca_pkg::SLOT_W-1:0]       r_res_bin;
    logic [bca_pkg::DENS_W-1:0]       r_res_dens;
    logic signed [bca_pkg::SUM_W-1:0] r_res_ps;
    logic signed [bca_pkg::SUM_W-1:0] r_res_ts;
    logic [bca_pkg::ERR_W-1:0]        r_res_err;
    logic                             r_res_rerr;

    logic                             r_oval;
    logic [bca_pkg::SLOT_W-1:0]       r_o_bin;
    logic [bca_pkg::DENS_W-1:0]       r_o_dens;
    logic signed [bca_pkg::SUM_W-1:0] r_o_ps;
    logic signed [bca_pkg::SUM_W-1:0] r_o_ts;
    logic [bca_pkg::ERR_W-1:0]        r_o_err;
    logic [bca_pkg::DENS_W-1:0]       r_o_total;
    logic                             r_o_rerr;

    logic [NBW-1:0] s_nb0;
    logic [NBW-1:0] s_nb1;
    logic           s_fc_two;
    logic [1:0]     s_kind;
    logic [NBW-1:0] s_nb;
    logic           s_cnst;
    logic signed [bca_pkg::VAL_W-1:0] s_v;
    logic signed [bca_pkg::VAL_W-1:0] s_bound;
    logic [NBW-1:0] s_idx_p1;
    logic           s_go;
    logic           s_code_bad;
    logic [BW-1:0]  s_bin;
    logic           s_fin;
    logic [CMBW-1:0] s_comb;

    logic signed [bca_pkg::MUL_A_W-1:0] s_mul_a;
    logic signed [bca_pkg::MUL_B_W-1:0] s_mul_b;
    logic signed [bca_pkg::MUL_P_W-1:0] s_mul_p;

    logic signed [32:0]               s_diff;
    logic [bca_pkg::SUM_W-1:0]        s_err_add;
    logic [bca_pkg::ERR_W-1:0]        s_err_new;
    logic [bca_pkg::DENS_W:0]         s_d0_add;
    logic [bca_pkg::DENS_W:0]         s_d1_add;
    logic [bca_pkg::DENS_W:0]         s_tot_add;
    logic [bca_pkg::DENS_W-1:0]       s_d0_new;

    logic                             s_we;
    logic signed [bca_pkg::SUM_W-1:0] s_wr_pred;
    logic signed [bca_pkg::SUM_W-1:0] s_wr_truth;
    logic [bca_pkg::ERR_W-1:0]        s_wr_err;
    logic signed [bca_pkg::SUM_W-1:0] s_rd_pred;
    logic signed [bca_pkg::SUM_W-1:0] s_rd_truth;
    logic [bca_pkg::ERR_W-1:0]        s_rd_err;

    function automatic logic [NBW-1:0] eff_bins(input logic [4:0] b);
        if (b == 5'd0) begin
            return NBW'(1);
        end
        if (32'(b) > MAX_BINS) begin
            return NBW'(MAX_BINS);
        end
        return NBW'(b);
    endfunction

    assign s_nb0    = eff_bins(i_cfg.bins_first);
    assign s_nb1    = eff_bins(i_cfg.bins_second);
    assign s_fc_two = (i_cfg.feature_count >= 2'd2) && (MAX_FEATURES >= 2);

    always_comb begin
        s_kind   = r_feat ? i_cfg.kind_second : i_cfg.kind_first;
        s_nb     = r_feat ? s_nb1 : s_nb0;
        s_cnst   = r_feat ? i_cfg.constant_second : i_cfg.constant_first;
        s_v      = r_feat ? r_v1 : r_v0;
        s_idx_p1 = NBW'(r_idx) + NBW'(1);
        s_bound  = '0;
        if (s_idx_p1 < s_nb) begin
            s_bound = r_feat ? r_bnd1[r_idx] : r_bnd0[r_idx];
        end
        s_go       = (s_idx_p1 < s_nb) && (s_bound <= s_v);
        s_code_bad = s_v[bca_pkg::VAL_W-1] || ($unsigned(s_v) >= 32'(s_nb));
        s_fin      = 1'b1;
        if (s_kind != bca_pkg::KIND_NUM) begin
            s_bin = BW'(s_v);
        end else if (s_cnst) begin
            s_bin = '0;
        end else begin
            s_bin = r_idx;
            s_fin = !s_go;
        end
    end

    assign s_comb = CMBW'(r_b0) + s_mul_p[CMBW-1:0];

    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        case (r_state)
            ST_COMB: begin
                s_mul_a = $signed(bca_pkg::MUL_A_W'(s_nb0));
                s_mul_b = $signed(bca_pkg::MUL_B_W'(r_b1));
            end
            ST_CHK: begin
                s_mul_a = bca_pkg::MUL_A_W'(r_pred);
                s_mul_b = $signed({2'b00, r_w});
            end
            ST_P: begin
                s_mul_a = bca_pkg::MUL_A_W'(r_truth);
                s_mul_b = $signed({2'b00, r_w});
            end
            ST_T: begin
                s_mul_a = $signed({1'b0, r_m});
                s_mul_b = $signed({2'b00, r_w});
            end
            ST_X: begin
                s_mul_a = $signed({1'b0, r_m});
                s_mul_b = $signed({1'b0, s_mul_p[16:0]});
            end
            ST_E0: begin
                s_mul_a = $signed({1'b0, r_m});
                s_mul_b = $signed({1'b0, r_x[33:17]});
            end
            ST_E1: begin
                s_mul_a = $signed({1'b0, r_m});
                s_mul_b = $signed(bca_pkg::MUL_B_W'(r_x[47:34]));
            end
            default: ;
        endcase
    end

    bca_mul u_mul (
        .i_clk (i_clk),
        .i_a   (s_mul_a),
        .i_b   (s_mul_b),
        .o_p   (s_mul_p)
    );

    assign s_diff    = 33'(r_truth) - 33'(r_pred);
    assign s_err_add = {1'b0, s_rd_err} + {1'b0, r_wsq};
    assign s_err_new = s_err_add[bca_pkg::SUM_W-1] ? bca_pkg::ERR_MAX
                                                   : s_err_add[bca_pkg::ERR_W-1:0];
    assign s_d0_add  = {1'b0, r_dens0[r_b0]} + (bca_pkg::DENS_W+1)'(r_w);
    assign s_d1_add  = {1'b0, r_dens1[r_b1]} + (bca_pkg::DENS_W+1)'(r_w);
    assign s_tot_add = {1'b0, r_total} + (bca_pkg::DENS_W+1)'(r_w);
    assign s_d0_new  = s_d0_add[bca_pkg::DENS_W] ? bca_pkg::DENS_MAX
                                                 : s_d0_add[bca_pkg::DENS_W-1:0];

    always_comb begin
        s_we       = 1'b0;
        s_wr_pred  = '0;
        s_wr_truth = '0;
        s_wr_err   = '0;
        if (r_state == ST_WR) begin
            s_we       = 1'b1;
            s_wr_pred  = r_ps_new;
            s_wr_truth = i_cfg.task_mode ? s_rd_truth : r_ts_new;
            s_wr_err   = i_cfg.task_mode ? s_rd_err : s_err_new;
        end else if (r_state == ST_CLEAR) begin
            s_we = 1'b1;
        end
    end

    bca_store #(
        .DEPTH (COMBINED_BINS),
        .AW    (CW)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (s_we),
        .i_addr     (r_addr),
        .i_pred_wr  (s_wr_pred),
        .i_truth_wr (s_wr_truth),
        .i_err_wr   (s_wr_err),
        .o_pred_rd  (s_rd_pred),
        .o_truth_rd (s_rd_truth),
        .o_err_rd   (s_rd_err)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cmd <= 1'b0;
            r_addr    <= '0;
            r_oval    <= 1'b0;
            r_feat    <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (r_oval && !i_stall) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    for (int k = 0; k < MAX_BINS; k++) begin
                        r_dens0[k] <= '0;
                        r_dens1[k] <= '0;
                    end
                    r_total <= '0;
                    r_addr  <= r_addr + CW'(1);
                    if (r_addr == CW'(COMBINED_BINS - 1)) begin
                        r_state   <= r_clr_cmd ? ST_DONE : ST_IDLE;
                        r_clr_cmd <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_func     <= i_func;
                        r_sel      <= i_feature_sel;
                        r_slot     <= i_slot;
                        r_v0       <= i_value_first;
                        r_v1       <= i_value_second;
                        r_w        <= i_weight;
                        r_pred     <= i_prediction;
                        r_truth    <= i_ground_truth;
                        r_res_bin  <= '0;
                        r_res_dens <= '0;
                        r_res_ps   <= '0;
                        r_res_ts   <= '0;
                        r_res_err  <= '0;
                        r_res_rerr <= 1'b0;
                        r_feat     <= 1'b0;
                        r_idx      <= '0;
                        r_b0       <= '0;
                        r_b1       <= '0;
                        unique case (i_func)
                            bca_pkg::FUNC_LOAD: begin
                                if (32'(i_slot) < NBOUNDS) begin
                                    if (i_feature_sel) begin
                                        r_bnd1[BW'(i_slot)] <= i_value_first;
                                    end else begin
                                        r_bnd0[BW'(i_slot)] <= i_value_first;
                                    end
                                end
                                r_state <= ST_DONE;
                            end
                            bca_pkg::FUNC_ACCUM: begin
                                r_state <= ST_SRCH;
                            end
                            bca_pkg::FUNC_RD_DENS: begin
                                if (i_slot == bca_pkg::CLEAR_SLOT) begin
                                    r_clr_cmd <= 1'b1;
                                    r_addr    <= '0;
                                    r_state   <= ST_CLEAR;
                                end else begin
                                    if (32'(i_slot) < MAX_BINS) begin
                                        r_res_dens <= i_feature_sel ? r_dens1[BW'(i_slot)]
                                                                    : r_dens0[BW'(i_slot)];
                                    end
                                    r_state <= ST_DONE;
                                end
                            end
                            bca_pkg::FUNC_RD_BIN: begin
                                r_res_bin <= i_slot;
                                r_addr    <= CW'(i_slot);
                                r_state   <= ST_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SRCH: begin
                    if (s_kind != bca_pkg::KIND_NUM && s_code_bad) begin
                        r_res_rerr <= 1'b1;
                        r_state    <= ST_DONE;
                    end else if (!s_fin) begin
                        r_idx <= r_idx + BW'(1);
                    end else begin
                        if (r_feat) begin
                            r_b1 <= s_bin;
                        end else begin
                            r_b0 <= s_bin;
                        end
                        if (!r_feat && s_fc_two) begin
                            r_feat <= 1'b1;
                            r_idx  <= '0;
                        end else begin
                            r_state <= ST_COMB;
                        end
                    end
                end
                ST_COMB: begin
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    r_comb <= s_comb;
                    if (32'(s_comb) >= COMBINED_BINS) begin
                        r_res_rerr <= 1'b1;
                        r_state    <= ST_DONE;
                    end else begin
                        r_addr  <= CW'(s_comb);
                        r_state <= ST_P;
                    end
                end
                ST_P: begin
                    r_pp    <= s_mul_p[47:0];
                    r_m     <= s_diff[32] ? 33'(-s_diff) : 33'(s_diff);
                    r_state <= ST_T;
                end
                ST_T: begin
                    r_tp    <= s_mul_p[47:0];
                    r_state <= ST_X;
                end
                ST_X: begin
                    r_x     <= s_mul_p[47:0];
                    r_state <= ST_E0;
                end
                ST_E0: begin
                    r_acc   <= ACC_W'(s_mul_p[49:0]);
                    r_state <= ST_E1;
                end
                ST_E1: begin
                    r_acc   <= r_acc + (ACC_W'(s_mul_p[49:0]) << 17);
                    r_state <= ST_E2;
                end
                ST_E2: begin
                    r_acc   <= r_acc + (ACC_W'(s_mul_p[49:0]) << 34);
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_wsq    <= (|r_acc[ACC_W-1:79]) ? bca_pkg::ERR_MAX : r_acc[78:16];
                    r_ps_new <= bca_pkg::sat_add64(s_rd_pred, 64'(r_pp));
                    r_ts_new <= bca_pkg::sat_add64(s_rd_truth, 64'(r_tp));
                    r_state  <= ST_WR;
                end
                ST_WR: begin
                    r_dens0[r_b0] <= s_d0_new;
                    if (s_fc_two) begin
                        r_dens1[r_b1] <= s_d1_add[bca_pkg::DENS_W] ? bca_pkg::DENS_MAX
                                                                   : s_d1_add[bca_pkg::DENS_W-1:0];
                    end
                    r_total <= s_tot_add[bca_pkg::DENS_W] ? bca_pkg::DENS_MAX
                                                          : s_tot_add[bca_pkg::DENS_W-1:0];
                    r_res_bin  <= bca_pkg::SLOT_W'(r_comb);
                    r_res_dens <= s_d0_new;
                    r_res_ps   <= s_wr_pred;
                    r_res_ts   <= s_wr_truth;
                    r_res_err  <= s_wr_err;
                    r_state    <= ST_DONE;
                end
                ST_RD: begin
                    r_state <= ST_RDW;
                end
                ST_RDW: begin
                    if (32'(r_slot) < COMBINED_BINS) begin
                        r_res_ps  <= s_rd_pred;
                        r_res_ts  <= s_rd_truth;
                        r_res_err <= s_rd_err;
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_oval || !i_stall) begin
                        r_oval    <= 1'b1;
                        r_o_bin   <= r_res_bin;
                        r_o_dens  <= r_res_dens;
                        r_o_ps    <= r_res_ps;
                        r_o_ts    <= r_res_ts;
                        r_o_err   <= r_res_err;
                        r_o_total <= r_total;
                        r_o_rerr  <= r_res_rerr;
                        r_state   <= ST_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall             = (r_state != ST_IDLE);
    assign o_valid             = r_oval;
    assign o_bin_index         = r_o_bin;
    assign o_density_count     = r_o_dens;
    assign o_prediction_sum    = r_o_ps;
    assign o_truth_sum         = r_o_ts;
    assign o_squared_error_sum = r_o_err;
    assign o_observation_total = r_o_total;
    assign o_range_error       = r_o_rerr;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH) |-> (NBW'(r_idx) < s_nb))
        else $error("boundary search index past bin count");

    a_range_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_bin_index == '0 && o_prediction_sum == '0
            && o_truth_sum == '0 && o_squared_error_sum == '0))
        else $error("range error result carries sums");

endmodule

### hdl/bucketize_conditional_accumulator_top.sv
// Top level of the bucketize conditional accumulator.
// Boundary load and density read go straight to the result state; a combined-bin read first
// passes through a read and a read-wait state. Accumulate runs the serial compare loop over the
// boundaries of each numerical search, then the shared multiplier schedule and the store update.
// One item at a time; the result register lets the next item start while a result waits.
// Reset and the clear command sweep every address of the bin memories, no input taken.
module bucketize_conditional_accumulator_top #(
    parameter int MAX_BINS      = bca_pkg::DEF_MAX_BINS,
    parameter int MAX_FEATURES  = bca_pkg::DEF_MAX_FEATURES,
    parameter int COMBINED_BINS = bca_pkg::DEF_COMBINED_BINS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bca_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bca_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [bca_pkg::FUNC_W-1:0]           i_func,
    input  logic                                 i_feature_sel,
    input  logic [bca_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_value_first,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_value_second,
    input  logic [bca_pkg::WGT_W-1:0]            i_weight,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_prediction,
    input  logic signed [bca_pkg::VAL_W-1:0]     i_ground_truth,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [bca_pkg::SLOT_W-1:0]           o_bin_index,
    output logic [bca_pkg::DENS_W-1:0]           o_density_count,
    output logic signed [bca_pkg::SUM_W-1:0]     o_prediction_sum,
    output logic signed [bca_pkg::SUM_W-1:0]     o_truth_sum,
    output logic [bca_pkg::ERR_W-1:0]            o_squared_error_sum,
    output logic [bca_pkg::DENS_W-1:0]           o_observation_total,
    output logic                                 o_range_error
);

    bca_pkg::t_cfg cfg;

    bca_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bca_core #(
        .MAX_BINS      (MAX_BINS),
        .MAX_FEATURES  (MAX_FEATURES),
        .COMBINED_BINS (COMBINED_BINS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_func              (i_func),
        .i_feature_sel       (i_feature_sel),
        .i_slot              (i_slot),
        .i_value_first       (i_value_first),
        .i_value_second      (i_value_second),
        .i_weight            (i_weight),
        .i_prediction        (i_prediction),
        .i_ground_truth      (i_ground_truth),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_bin_index         (o_bin_index),
        .o_density_count     (o_density_count),
        .o_prediction_sum    (o_prediction_sum),
        .o_truth_sum         (o_truth_sum),
        .o_squared_error_sum (o_squared_error_sum),
        .o_observation_total (o_observation_total),
        .o_range_error       (o_range_error)
    );

endmodule
